// File: sv/amt_pkg.sv
// Package of the adaptive mean threshold block: sizes, codes and the
// divider request and response types. No dependencies.
`default_nettype none
package amt_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_RADIUS = 7;
	localparam int RING_ROWS  = 2 * MAX_RADIUS + 1;

	localparam int PIX_W    = 8;
	localparam int DIM_W    = 11;
	localparam int OFS_W    = 9;
	localparam int RADREG_W = 3;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 11;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int RING_W   = $clog2(RING_ROWS);
	localparam int ADDR_W   = RING_W + COL_W;
	localparam int RAM_DEPTH = (1 << ADDR_W);
	localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
	localparam int SPAN_W   = $clog2(RING_ROWS + 1);
	localparam int CNT_W    = $clog2(RING_ROWS * RING_ROWS + 1);
	localparam int SUM_W    = $clog2(RING_ROWS * RING_ROWS * 255 + 1);
	localparam int RUN_W    = $clog2(MAX_RADIUS + 2);

	localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
	localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 4'd3;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} amt_op_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} amt_div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} amt_div_rsp_t;
endpackage
`default_nettype wire

// File: sv/amt_if.sv
// Channel interfaces of the adaptive mean threshold block: pixel input,
// result output and configuration write. Depends on amt_pkg.
`default_nettype none
interface amt_pix_if;
	import amt_pkg::*;
	logic             valid;
	logic             ready;
	logic             operation;
	logic [PIX_W-1:0] pixel_in;
	modport source (output valid, operation, pixel_in, input ready);
	modport sink (input valid, operation, pixel_in, output ready);
endinterface

interface amt_res_if;
	import amt_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             last_of_run;
	logic             frame_end;
	modport source (output valid, pixel_out, last_of_run, frame_end, input ready);
	modport sink (input valid, pixel_out, last_of_run, frame_end, output ready);
endinterface

interface amt_cfg_if;
	import amt_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/amt_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none
module amt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: sv/amt_div.sv
// Iterative restoring divider, one quotient bit per cycle, for the window
// mean. Depends on amt_pkg.
`default_nettype none
module amt_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire amt_pkg::amt_div_req_t req,
	output amt_pkg::amt_div_rsp_t      rsp
);
	import amt_pkg::*;

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [STEP_W-1:0]  step_q;
	logic [SUM_W-1:0]   quo_q;
	logic [CNT_W:0]     rem_q;
	logic [CNT_W-1:0]   dvs_q;
	logic [CNT_W+1:0]   trial;

	assign trial = {rem_q, quo_q[SUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
				quo_q  <= req.dividend;
				rem_q  <= '0;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				if (trial >= {2'b00, dvs_q}) begin
					rem_q <= (CNT_W + 1)'(trial - {2'b00, dvs_q});
					quo_q <= {quo_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= (CNT_W + 1)'(trial);
					quo_q <= {quo_q[SUM_W-2:0], 1'b0};
				end
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule
`default_nettype wire

// File: sv/adaptive_mean_threshold_top.sv
// Top level of the adaptive mean threshold block: line store RAM, window
// sequencer, divider and result register. Depends on amt_pkg, amt_if,
// amt_ram and amt_div.
//
// Usage: pixels of a frame arrive in raster order as beats on pix_in with
// operation 0. Results leave on pix_out in raster order, lagging the input
// by radius rows and radius columns; the last pixel of a row releases the
// rest of the pending result row, with last_of_run on the final beat of
// each run. After the frame, each beat with operation 1 fetches one more
// pending result. Configuration writes on cfg to indices 0 to 3 restart the
// frame; writes are accepted only while the block is idle.
// Flow: one item is handled at a time. Each result sums its window, with
// fewer reads where the window is clipped: the window is summed one line
// store read per cycle from a single RAM port, then the divider start state
// and the divider follow. A pixel that releases no result leaves the block idle.
// Reset sets radius 1, offset 0, a 1024 by 1024 frame and all pointers to
// zero; the line store needs no clearing. When the receiver stalls, the
// result register holds its beat and the sequencer waits before loading
// the next one.
`default_nettype none
module adaptive_mean_threshold_top (
	input wire logic clk,
	input wire logic arst_n,
	amt_cfg_if.sink  cfg,
	amt_pix_if.sink  pix_in,
	amt_res_if.source pix_out
);
	import amt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_SETUP, S_PIX, S_SUM, S_DIV, S_WAITDIV, S_EMIT
	} state_t;

	state_t state_q;

	logic [RADREG_W-1:0]    radius_q;
	logic signed [OFS_W-1:0] offset_q;
	logic [DIM_W-1:0]       width_q, height_q;
	logic [DIM_W-1:0]       eff_w, eff_h, eff_r11;
	logic [RAD_W-1:0]       eff_r;

	logic [ROW_W-1:0]  in_row_q, out_row_q, tgt_q, y_q;
	logic [COL_W-1:0]  in_col_q, out_col_q, x_q, c0_q, c1_q;
	logic [ROW_W-1:0]  r1_q;
	logic [RING_W-1:0] in_ring_q, out_ring_q, y_ring_q;
	logic              received_q, mode_row_q, issue_done_q, rd_pend_s1;
	logic [RUN_W-1:0]  run_n_q;
	logic [SUM_W-1:0]  sum_q, mean_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PIX_W-1:0]  pix_q;

	logic              out_valid_q, out_last_q, out_fe_q;
	logic [PIX_W-1:0]  out_pix_q;

	logic              in_acc, ram_we, emit_go;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [PIX_W-1:0]  ram_rdata;
	amt_div_req_t      div_req;
	amt_div_rsp_t      div_rsp;

	logic [DIM_W-1:0]  wi, wj, wr0, wr1, wc0, wc1;
	logic [SPAN_W-1:0] span_r, span_c;
	logic [RING_W-1:0] ring_back, ring0;
	logic signed [SUM_W+1:0] thr;
	logic              below, fe, more, last_in_col, last_out_col;
	logic [ROW_W-1:0]  next_out_row;
	logic [RING_W-1:0] in_ring_inc, out_ring_inc, y_ring_inc;

	always_comb begin
		eff_r   = (RAD_W'(radius_q) > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
			: RAD_W'(radius_q);
		eff_w   = (width_q == '0) ? DIM_W'(1)
			: ((width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q);
		eff_h   = (height_q == '0) ? DIM_W'(1)
			: ((height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q);
		eff_r11 = DIM_W'(eff_r);
	end

	always_comb begin
		wi   = DIM_W'(out_row_q);
		wj   = DIM_W'(out_col_q);
		wr0  = (wi >= eff_r11) ? wi - eff_r11 : '0;
		wr1  = (wi + eff_r11 > eff_h - 1'b1) ? eff_h - 1'b1 : wi + eff_r11;
		wc0  = (wj >= eff_r11) ? wj - eff_r11 : '0;
		wc1  = (wj + eff_r11 > eff_w - 1'b1) ? eff_w - 1'b1 : wj + eff_r11;
		span_r = SPAN_W'(wr1 - wr0 + 1'b1);
		span_c = SPAN_W'(wc1 - wc0 + 1'b1);
		ring_back = RING_W'(wi - wr0);
		ring0  = (out_ring_q >= ring_back) ? out_ring_q - ring_back
			: RING_W'(out_ring_q + RING_W'(RING_ROWS) - ring_back);
	end

	always_comb begin
		in_ring_inc  = (in_ring_q == RING_W'(RING_ROWS - 1)) ? '0 : in_ring_q + 1'b1;
		out_ring_inc = (out_ring_q == RING_W'(RING_ROWS - 1)) ? '0 : out_ring_q + 1'b1;
		y_ring_inc   = (y_ring_q == RING_W'(RING_ROWS - 1)) ? '0 : y_ring_q + 1'b1;
		last_in_col  = (DIM_W'(in_col_q) + 1'b1 >= eff_w);
		last_out_col = (DIM_W'(out_col_q) + 1'b1 >= eff_w);
		fe           = (DIM_W'(out_row_q) == eff_h - 1'b1) && (DIM_W'(out_col_q) == eff_w - 1'b1);
		next_out_row = last_out_col ? out_row_q + 1'b1 : out_row_q;
		more         = mode_row_q && !fe && (run_n_q != RUN_W'(MAX_RADIUS))
			&& (next_out_row == tgt_q);
		thr          = $signed({2'b00, mean_q}) - (SUM_W + 2)'(offset_q);
		below        = $signed((SUM_W + 2)'({1'b0, pix_q})) < thr;
	end

	assign in_acc     = pix_in.valid && pix_in.ready;
	assign ram_we     = in_acc && (pix_in.operation == OP_PIXEL) && !received_q;
	assign ram_waddr  = {in_ring_q, in_col_q};
	assign ram_raddr  = (state_q == S_SETUP) ? {out_ring_q, out_col_q} : {y_ring_q, x_q};
	assign emit_go    = (state_q == S_EMIT) && (!out_valid_q || pix_out.ready);

	assign pix_in.ready = (state_q == S_IDLE) && !cfg.valid;
	assign cfg.ready    = (state_q == S_IDLE);

	assign div_req.start    = (state_q == S_DIV);
	assign div_req.dividend = sum_q;
	assign div_req.divisor  = cnt_q;

	amt_ram #(
		.WIDTH(PIX_W),
		.DEPTH(RAM_DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(pix_in.pixel_in),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	amt_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			radius_q     <= RADREG_W'(1);
			offset_q     <= '0;
			width_q      <= DIM_W'(MAX_WIDTH);
			height_q     <= DIM_W'(MAX_HEIGHT);
			in_row_q     <= '0;
			in_col_q     <= '0;
			in_ring_q    <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
			out_ring_q   <= '0;
			received_q   <= 1'b0;
			mode_row_q   <= 1'b0;
			run_n_q      <= '0;
			issue_done_q <= 1'b0;
			rd_pend_s1   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid && cfg.ready && cfg.index <= CFG_HEIGHT) begin
				case (cfg.index)
					CFG_RADIUS: radius_q <= cfg.data[RADREG_W-1:0];
					CFG_OFFSET: offset_q <= $signed(cfg.data[OFS_W-1:0]);
					CFG_WIDTH:  width_q  <= cfg.data[DIM_W-1:0];
					default:    height_q <= cfg.data[DIM_W-1:0];
				endcase
				in_row_q   <= '0;
				in_col_q   <= '0;
				in_ring_q  <= '0;
				out_row_q  <= '0;
				out_col_q  <= '0;
				out_ring_q <= '0;
				received_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (pix_in.operation == OP_DRAIN) begin
							if (received_q) begin
								mode_row_q <= 1'b0;
								state_q    <= S_SETUP;
							end
						end else if (!received_q) begin
							if (last_in_col) begin
								in_col_q  <= '0;
								in_row_q  <= in_row_q + 1'b1;
								in_ring_q <= in_ring_inc;
								if (DIM_W'(in_row_q) + 1'b1 >= eff_h) begin
									received_q <= 1'b1;
								end
							end else begin
								in_col_q <= in_col_q + 1'b1;
							end
							if (DIM_W'(in_row_q) >= eff_r11) begin
								if (last_in_col) begin
									mode_row_q <= 1'b1;
									tgt_q      <= ROW_W'(DIM_W'(in_row_q) - eff_r11);
									run_n_q    <= '0;
									state_q    <= S_SETUP;
								end else if (DIM_W'(in_col_q) >= eff_r11) begin
									mode_row_q <= 1'b0;
									state_q    <= S_SETUP;
								end
							end
						end
					end
				end
				S_SETUP: begin
					if (mode_row_q && out_row_q != tgt_q) begin
						state_q <= S_IDLE;
					end else begin
						y_q      <= ROW_W'(wr0);
						y_ring_q <= ring0;
						r1_q     <= ROW_W'(wr1);
						x_q      <= COL_W'(wc0);
						c0_q     <= COL_W'(wc0);
						c1_q     <= COL_W'(wc1);
						cnt_q    <= CNT_W'(span_r * span_c);
						state_q  <= S_PIX;
					end
				end
				S_PIX: begin
					pix_q        <= ram_rdata;
					sum_q        <= '0;
					issue_done_q <= 1'b0;
					rd_pend_s1   <= 1'b0;
					state_q      <= S_SUM;
				end
				S_SUM: begin
					rd_pend_s1 <= !issue_done_q;
					if (!issue_done_q) begin
						if (x_q == c1_q) begin
							x_q <= c0_q;
							if (y_q == r1_q) begin
								issue_done_q <= 1'b1;
							end else begin
								y_q      <= y_q + 1'b1;
								y_ring_q <= y_ring_inc;
							end
						end else begin
							x_q <= x_q + 1'b1;
						end
					end
					if (rd_pend_s1) begin
						sum_q <= sum_q + SUM_W'(ram_rdata);
					end
					if (issue_done_q && !rd_pend_s1) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					state_q <= S_WAITDIV;
				end
				S_WAITDIV: begin
					if (div_rsp.done) begin
						mean_q  <= div_rsp.quotient;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						out_pix_q   <= below ? PIX_BLACK : PIX_WHITE;
						out_fe_q    <= fe;
						out_last_q  <= !more;
						run_n_q     <= run_n_q + 1'b1;
						if (fe) begin
							in_row_q   <= '0;
							in_col_q   <= '0;
							in_ring_q  <= '0;
							out_row_q  <= '0;
							out_col_q  <= '0;
							out_ring_q <= '0;
							received_q <= 1'b0;
						end else if (last_out_col) begin
							out_col_q  <= '0;
							out_row_q  <= out_row_q + 1'b1;
							out_ring_q <= out_ring_inc;
						end else begin
							out_col_q <= out_col_q + 1'b1;
						end
						state_q <= more ? S_SETUP : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pix_out.valid       = out_valid_q;
	assign pix_out.pixel_out   = out_pix_q;
	assign pix_out.last_of_run = out_last_q;
	assign pix_out.frame_end   = out_fe_q;

	a_binary_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_pix_q == PIX_BLACK || out_pix_q == PIX_WHITE))
		else $error("result is neither black nor white");

	a_fe_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_fe_q) |-> out_last_q)
		else $error("frame end beat does not close its run");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_IDLE))
		else $error("line store written while a window is in flight");

	a_div_result: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_WAITDIV))
		else $error("divider finished outside its wait state");
endmodule
`default_nettype wire

// File: dv/tb_adaptive_mean_threshold_top.sv
// Self-checking testbench of adaptive_mean_threshold_top: a directed table, then random frames
// checked against a behavioral threshold predictor. Depends on amt_pkg, amt_if and the RTL.
`default_nettype none
module tb_adaptive_mean_threshold_top;
	timeunit 1ns;
	timeprecision 1ps;
	import amt_pkg::*;

	typedef struct {
		logic [PIX_W-1:0] level;
		logic             last;
		logic             fend;
	} thr_result_t;

	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DAT_W-1:0] data;
		amt_op_t              op;
		logic [PIX_W-1:0]     pix;
		bit                   typed;
		logic [PIX_W-1:0]     t_level;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #6 clk = ~clk;

	amt_cfg_if cfg_ch();
	amt_pix_if pix_ch();
	amt_res_if res_ch();

	adaptive_mean_threshold_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch.sink),
		.pix_in(pix_ch.sink),
		.pix_out(res_ch.source)
	);

	logic [PIX_W-1:0]     line_mem [RING_ROWS*MAX_WIDTH];
	logic [RADREG_W-1:0]  rad_reg;
	logic [OFS_W-1:0]     ofs_reg;
	logic [DIM_W-1:0]     wid_reg;
	logic [DIM_W-1:0]     hgt_reg;
	int unsigned          in_row, in_col, out_row, out_col;
	bit                   frame_in;
	thr_result_t          awaited_levels[$];
	int                   fail_count = 0;
	bit                   hold_req = 1'b0;
	int                   burst_left = 0;

	function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned lim);
		if (v == 0) return 1;
		return (v > lim) ? lim : v;
	endfunction

	function automatic void restart_frame();
		in_row = 0;
		in_col = 0;
		out_row = 0;
		out_col = 0;
		frame_in = 1'b0;
	endfunction

	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
		case (idx)
			CFG_RADIUS: rad_reg = d[RADREG_W-1:0];
			CFG_OFFSET: ofs_reg = d[OFS_W-1:0];
			CFG_WIDTH: wid_reg = d;
			CFG_HEIGHT: hgt_reg = d;
			default: return;
		endcase
		restart_frame();
	endfunction

	function automatic thr_result_t window_threshold();
		int unsigned rr, ww, hh, i, j, r0, r1, c0, c1, sum, cnt, mean, y, x;
		int pv, ofs;
		thr_result_t res;
		rr = (rad_reg > MAX_RADIUS) ? MAX_RADIUS : rad_reg;
		ww = eff_dim(wid_reg, MAX_WIDTH);
		hh = eff_dim(hgt_reg, MAX_HEIGHT);
		i = out_row;
		j = out_col;
		r0 = (i >= rr) ? i - rr : 0;
		r1 = (i + rr > hh - 1) ? hh - 1 : i + rr;
		c0 = (j >= rr) ? j - rr : 0;
		c1 = (j + rr > ww - 1) ? ww - 1 : j + rr;
		sum = 0;
		for (y = r0; y <= r1; y++)
			for (x = c0; x <= c1; x++)
				sum += line_mem[(y % RING_ROWS) * MAX_WIDTH + x];
		cnt = (r1 - r0 + 1) * (c1 - c0 + 1);
		mean = sum / cnt;
		pv = line_mem[(i % RING_ROWS) * MAX_WIDTH + j];
		ofs = $signed(ofs_reg);
		res.level = (pv < int'(mean) - ofs) ? PIX_BLACK : PIX_WHITE;
		res.last = 1'b0;
		res.fend = (i == hh - 1 && j == ww - 1);
		if (res.fend) begin
			restart_frame();
		end else if (j + 1 >= ww) begin
			out_col = 0;
			out_row = i + 1;
		end else begin
			out_col = j + 1;
		end
		return res;
	endfunction

	function automatic void predict_threshold(amt_op_t op, logic [PIX_W-1:0] pix,
			ref thr_result_t outq[$]);
		int unsigned rr, ww, hh, r, c;
		thr_result_t one;
		rr = (rad_reg > MAX_RADIUS) ? MAX_RADIUS : rad_reg;
		ww = eff_dim(wid_reg, MAX_WIDTH);
		hh = eff_dim(hgt_reg, MAX_HEIGHT);
		outq = {};
		if (op == OP_DRAIN) begin
			if (frame_in) outq.push_back(window_threshold());
		end else if (!frame_in) begin
			r = in_row;
			c = in_col;
			line_mem[(r % RING_ROWS) * MAX_WIDTH + c] = pix;
			if (c + 1 >= ww) begin
				in_col = 0;
				in_row = r + 1;
				if (r + 1 >= hh) frame_in = 1'b1;
			end else begin
				in_col = c + 1;
			end
			if (r >= rr) begin
				if (c + 1 >= ww) begin
					while (outq.size() < MAX_RADIUS + 1 && out_row == r - rr) begin
						one = window_threshold();
						outq.push_back(one);
						if (one.fend) break;
					end
				end else if (c >= rr) begin
					outq.push_back(window_threshold());
				end
			end
		end
		if (outq.size() > 0) outq[outq.size()-1].last = 1'b1;
	endfunction

	task automatic drive_item(amt_op_t op, logic [PIX_W-1:0] pix, bit typed,
			logic [PIX_W-1:0] t_level);
		thr_result_t got[$];
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if ($urandom_range(0, 30) == 0) gap = $urandom_range(20, 60);
			if (gap > 0) begin
				pix_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		pix_ch.operation = op;
		pix_ch.pixel_in = pix;
		pix_ch.valid = 1'b1;
		do @(posedge clk); while (!pix_ch.ready);
		predict_threshold(op, pix, got);
		if (typed && got.size() == 1) begin
			got[0].level = t_level;
			got[0].last = 1'b1;
			got[0].fend = 1'b1;
		end
		foreach (got[k]) awaited_levels.push_back(got[k]);
	endtask

	task automatic settle_block();
		@(negedge clk);
		pix_ch.valid = 1'b0;
		while (awaited_levels.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
		@(negedge clk);
		cfg_ch.index = idx;
		cfg_ch.data = d;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_register(idx, d);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic plan_row_t cw(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
		return '{1'b1, idx, d, OP_PIXEL, '0, 1'b0, '0};
	endfunction

	function automatic plan_row_t px(amt_op_t op, logic [PIX_W-1:0] p);
		return '{1'b0, CFG_RADIUS, '0, op, p, 1'b0, '0};
	endfunction

	function automatic plan_row_t pt(logic [PIX_W-1:0] p, logic [PIX_W-1:0] lvl);
		return '{1'b0, CFG_RADIUS, '0, OP_PIXEL, p, 1'b1, lvl};
	endfunction

	always @(posedge clk) begin
		thr_result_t exp_r;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (awaited_levels.size() == 0) begin
				$error("unexpected result beat pixel_out=%0d", res_ch.pixel_out);
				fail_count++;
			end else begin
				exp_r = awaited_levels.pop_front();
				if (res_ch.pixel_out !== exp_r.level) begin
					$error("pixel_out expected %0d actual %0d", exp_r.level, res_ch.pixel_out);
					fail_count++;
				end
				if (res_ch.last_of_run !== exp_r.last) begin
					$error("last_of_run expected %0d actual %0d", exp_r.last,
						res_ch.last_of_run);
					fail_count++;
				end
				if (res_ch.frame_end !== exp_r.fend) begin
					$error("frame_end expected %0d actual %0d", exp_r.fend, res_ch.frame_end);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int unsigned rx_cyc;
		int mode;
		rx_cyc = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ch.ready = 1'b0;
				repeat (3000) @(negedge clk);
				hold_req = 1'b0;
			end
			rx_cyc++;
			mode = (rx_cyc / 97) % 4;
			case (mode)
				0: res_ch.ready = 1'b1;
				1: res_ch.ready = 1'($urandom_range(0, 1));
				2: res_ch.ready = ($urandom_range(0, 3) == 0);
				default: res_ch.ready = ($urandom_range(0, 15) != 0);
			endcase
		end
	end

	initial begin
		#15000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		plan_row_t plan[$];
		int sent, ww, hh, total, cut, n;
		bit first_phase;
		logic [PIX_W-1:0] p;
		pix_ch.valid = 1'b0;
		pix_ch.operation = OP_PIXEL;
		pix_ch.pixel_in = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_RADIUS;
		cfg_ch.data = '0;
		rad_reg = 3'd1;
		ofs_reg = '0;
		wid_reg = 11'd1024;
		hgt_reg = 11'd1024;
		restart_frame();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		plan = '{cw(CFG_RADIUS, 0), cw(CFG_WIDTH, 1), cw(CFG_HEIGHT, 1), cw(CFG_OFFSET, 0),
			pt(8'd0, PIX_WHITE), pt(8'd255, PIX_WHITE),
			cw(CFG_OFFSET, 11'h101), pt(8'd0, PIX_BLACK), pt(8'd255, PIX_BLACK),
			cw(CFG_OFFSET, 255), pt(8'd0, PIX_WHITE), px(OP_DRAIN, 8'd0),
			cw(CFG_RADIUS, 7), cw(CFG_WIDTH, 3), cw(CFG_HEIGHT, 2), cw(CFG_OFFSET, 0),
			px(OP_DRAIN, 8'd9), px(OP_PIXEL, 8'd0), px(OP_PIXEL, 8'd255),
			px(OP_PIXEL, 8'd128), px(OP_PIXEL, 8'd1), px(OP_PIXEL, 8'd254),
			px(OP_PIXEL, 8'd127), px(OP_PIXEL, 8'd200),
			px(OP_DRAIN, 8'd0), px(OP_DRAIN, 8'd0), px(OP_DRAIN, 8'd0), px(OP_DRAIN, 8'd0),
			px(OP_DRAIN, 8'd0), px(OP_DRAIN, 8'd0), px(OP_DRAIN, 8'd0),
			cw(CFG_WIDTH, 2047), cw(CFG_HEIGHT, 1024), cw(CFG_RADIUS, 0),
			px(OP_PIXEL, 8'hAA), px(OP_PIXEL, 8'h55), px(OP_PIXEL, 8'hFF)};
		foreach (plan[k]) begin
			if (plan[k].is_cfg) begin
				settle_block();
				write_register(plan[k].idx, plan[k].data);
			end else begin
				drive_item(plan[k].op, plan[k].pix, plan[k].typed, plan[k].t_level);
			end
		end

		sent = 0;
		first_phase = 1'b1;
		while (sent < 270) begin
			settle_block();
			write_register(CFG_RADIUS, CFG_DAT_W'($urandom_range(0, 7)));
			case ($urandom_range(0, 5))
				0: write_register(CFG_OFFSET, 11'h101);
				1: write_register(CFG_OFFSET, 11'd255);
				default: write_register(CFG_OFFSET, {2'b00, 9'($urandom_range(0, 511))});
			endcase
			write_register(CFG_WIDTH, CFG_DAT_W'($urandom_range(0, 12)));
			write_register(CFG_HEIGHT, CFG_DAT_W'($urandom_range(0, 8)));
			ww = eff_dim(wid_reg, MAX_WIDTH);
			hh = eff_dim(hgt_reg, MAX_HEIGHT);
			total = ww * hh;
			cut = ($urandom_range(0, 6) == 0) ? $urandom_range(0, total - 1) : total;
			if (!first_phase) hold_req = hold_req;
			for (n = 0; n < cut; n++) begin
				if (n == total / 2 && sent > 40 && first_phase) begin
					hold_req = 1'b1;
					first_phase = 1'b0;
				end
				if ($urandom_range(0, 12) == 0) drive_item(OP_DRAIN, PIX_W'($urandom), 1'b0, '0);
				case ($urandom_range(0, 7))
					0: p = 8'd0;
					1: p = 8'd255;
					default: p = PIX_W'($urandom);
				endcase
				drive_item(OP_PIXEL, p, 1'b0, '0);
				sent++;
			end
			if (cut == total) begin
				if ($urandom_range(0, 3) == 0) drive_item(OP_PIXEL, PIX_W'($urandom), 1'b0, '0);
				while (frame_in) begin
					drive_item(OP_DRAIN, PIX_W'($urandom), 1'b0, '0);
					sent++;
				end
				if ($urandom_range(0, 3) == 0) drive_item(OP_DRAIN, PIX_W'($urandom), 1'b0, '0);
			end
		end

		settle_block();
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
sv/amt_pkg.sv
sv/amt_if.sv
sv/amt_ram.sv
sv/amt_div.sv
sv/adaptive_mean_threshold_top.sv
dv/tb_adaptive_mean_threshold_top.sv
